// ===== hdl/crr_pkg.sv =====
package crr_pkg;
  localparam int SampleW = 16;
  localparam int RegW    = 18;
  localparam int PhaseW  = 19;
  localparam int TW      = 16;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegStep   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPeriod = 1'b1;

  // Handshake between the sequencer and the serial divider.
  typedef struct packed {
    logic start;
    logic [PhaseW-1:0] phase;
    logic [RegW-1:0] period;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [TW-1:0] quot;
  } div_rsp_t;
endpackage

// ===== hdl/crr_divider.sv =====
// Restoring divider, one quotient bit per cycle: t = floor(phase*2^15/period).
// phase < period always holds on entry, so the integer part of the quotient is
// zero and the remainder starts as phase; 15 fraction steps give t < 2^15.
module crr_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  crr_pkg::div_req_t req,
  output crr_pkg::div_rsp_t rsp
);
  import crr_pkg::*;

  localparam int CntW = $clog2(TW + 1);

  logic [RegW:0]     rem_r, rem_nxt;
  logic [RegW-1:0]   den_r;
  logic [TW-1:0]     quot_r, quot_nxt;
  logic [CntW-1:0]   cnt_r;
  logic              busy_r, done_r;
  logic [RegW+1:0]   trial;

  // Shift remainder left, try subtracting the divisor.
  always_comb begin
    trial    = {rem_r, 1'b0} - {2'b00, den_r};
    rem_nxt  = trial[RegW+1] ? {rem_r[RegW-1:0], 1'b0} : trial[RegW:0];
    quot_nxt = {quot_r[TW-2:0], ~trial[RegW+1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(TW - 1);
        // remainder starts at phase; each step brings in one zero bit
        rem_r  <= req.phase;
        den_r  <= req.period;
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= quot_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
endmodule

// ===== hdl/crr_mac.sv =====
// Shift-add multiplier: product of a signed operand by t (Q15, unsigned)
// one bit of t per cycle, then floor shift right by 15.
module crr_mac (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [23:0]       opnd,
  input  logic [crr_pkg::TW-1:0]   tval,
  output logic                     done,
  output logic signed [23:0]       res
);
  import crr_pkg::*;

  localparam int CntW = $clog2(TW + 1);

  logic signed [23+TW:0] acc_r;
  logic signed [23+TW:0] mcand_r;
  logic [TW-1:0]         mplier_r;
  logic [CntW-1:0]       cnt_r;
  logic                  busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        cnt_r    <= CntW'(TW);
        acc_r    <= '0;
        mcand_r  <= (24+TW)'(opnd);
        mplier_r <= tval;
      end else if (busy_r) begin
        if (mplier_r[0]) acc_r <= acc_r + mcand_r;
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = 24'(acc_r >>> 15);
endmodule

// ===== hdl/cubic_rational_resampler_top.sv =====
// Catmull-Rom cubic rational-rate resampler.
// in_*  : one signed 16-bit sample per item (tdata[15:0]).
// out_* : result items: tdata[15:0] sample, tlast marks the final result of
//         an input, tuser[0] flags a register error (sample zero).
// cfg_* : index 0 phase_step, index 1 phase_period; write while idle.
// One input is taken at a time. The first two inputs only fill the window.
// Each result is computed by a serial divider for t, then three shift-add
// multiplies in Horner order, plus start, done and sequencing steps;
// up to 64 results per input.
// in_tready is high only while the sequencer waits for an input.
// A result is held in the output register until taken; while out_tready is
// low the sequencer stalls and no further input is accepted.
// Synchronous active-low reset clears the window, phase, fill count and
// registers (step = period = 1); no clearing pass is needed.
module cubic_rational_resampler_top #(
  parameter int MAX_RUN    = 64,
  parameter int RATE_LIMIT = 192000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  output logic        out_tlast,  // last
  output logic        out_tuser,  // [0] config_error
  input  logic        cfg_we,
  input  logic [crr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [crr_pkg::RegW-1:0]    cfg_data
);
  import crr_pkg::*;

  localparam int RunW = $clog2(MAX_RUN + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_M3, S_M2, S_M1, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic [RegW-1:0]   step_r, period_r;
  logic [PhaseW-1:0] phase_r;
  logic [1:0]        fill_r;
  logic signed [15:0] w0_r, w1_r, w2_r, w3_r;
  logic [RunW-1:0]   run_r;
  logic [TW-1:0]     t_r;
  logic signed [23:0] k1_r, k2_r, k3_r, acc_r;
  logic              div_start_r, mac_start_r;
  logic signed [23:0] mac_op_r;

  div_req_t dreq;
  div_rsp_t drsp;
  logic mac_done;
  logic signed [23:0] mac_res;

  assign dreq.start  = div_start_r;
  assign dreq.phase  = phase_r;
  assign dreq.period = period_r;

  crr_divider u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));
  crr_mac u_mac (.clk, .rst_n, .start(mac_start_r), .opnd(mac_op_r), .tval(t_r),
                 .done(mac_done), .res(mac_res));

  // register sanity: zero, above limit, or period > MAX_RUN*step
  logic cfg_bad;
  logic [RegW+RunW:0] run_span;
  always_comb begin
    run_span = (RegW+RunW+1)'(step_r) * (RegW+RunW+1)'(MAX_RUN);
    cfg_bad = (step_r == '0) || (period_r == '0) ||
              (32'(step_r) > 32'(RATE_LIMIT)) || (32'(period_r) > 32'(RATE_LIMIT)) ||
              ((RegW+RunW+1)'(period_r) > run_span);
  end

  assign in_tready = (state_r == S_IDLE) && !out_tvalid;

  logic signed [17:0] bo, co;
  logic signed [23:0] final_v;
  logic [PhaseW:0] ph_add;
  always_comb begin
    bo = 18'(w1_r);
    co = 18'(w2_r);
    final_v = 24'(w1_r) + (acc_r >>> 1);
    ph_add = (PhaseW+1)'(phase_r) + (PhaseW+1)'(step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= RegW'(1);
      period_r <= RegW'(1);
      phase_r <= '0;
      fill_r <= '0;
      w0_r <= '0; w1_r <= '0; w2_r <= '0; w3_r <= '0;
      out_tvalid <= 1'b0;
      div_start_r <= 1'b0;
      mac_start_r <= 1'b0;
      run_r <= '0;
    end else begin
      div_start_r <= 1'b0;
      mac_start_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == RegStep) step_r <= cfg_data;
        else period_r <= cfg_data;
      end
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          if (cfg_bad) begin
            out_tdata <= '0; out_tlast <= 1'b1; out_tuser <= 1'b1;
            out_tvalid <= 1'b1;
          end else if (fill_r == 2'd0) begin
            w1_r <= in_tdata; fill_r <= 2'd1;
          end else if (fill_r == 2'd1) begin
            w2_r <= in_tdata; fill_r <= 2'd2;
          end else begin
            if (fill_r == 2'd2) fill_r <= 2'd3;
            else begin
              phase_r <= (phase_r >= PhaseW'(period_r)) ? phase_r - PhaseW'(period_r) : '0;
              w0_r <= w1_r; w1_r <= w2_r; w2_r <= w3_r;
            end
            w3_r <= in_tdata;
            run_r <= '0;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          // window coefficients
          k1_r <= 24'(co) - 24'(w0_r);
          k2_r <= 24'(w0_r) * 24'sd2 - 24'(bo) * 24'sd5 + 24'(co) * 24'sd4 - 24'(w3_r);
          k3_r <= 24'(w3_r) - 24'(w0_r) + (24'(bo) - 24'(co)) * 24'sd3;
          if (phase_r < PhaseW'(period_r) && run_r != RunW'(MAX_RUN)) begin
            div_start_r <= 1'b1;
            state_r <= S_DIV;
          end else state_r <= S_IDLE;
        end
        S_DIV: if (drsp.done) begin
          t_r <= drsp.quot;
          mac_op_r <= k3_r; mac_start_r <= 1'b1;
          state_r <= S_M3;
        end
        S_M3: if (mac_done) begin
          mac_op_r <= k2_r + mac_res; mac_start_r <= 1'b1; state_r <= S_M2;
        end
        S_M2: if (mac_done) begin
          mac_op_r <= k1_r + mac_res; mac_start_r <= 1'b1; state_r <= S_M1;
        end
        S_M1: if (mac_done) begin
          acc_r <= mac_res; state_r <= S_FIN;
        end
        S_FIN: if (!out_tvalid) begin
          out_tdata <= (final_v > 24'sd32767) ? 16'h7fff :
                       (final_v < -24'sd32768) ? 16'h8000 : final_v[15:0];
          out_tuser <= 1'b0;
          phase_r <= ph_add[PhaseW-1:0];
          run_r <= run_r + 1'b1;
          out_tlast <= !((ph_add[PhaseW-1:0] < PhaseW'(period_r)) &&
                         (run_r + 1'b1 != RunW'(MAX_RUN)));
          out_tvalid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_tvalid || out_tready) begin
          state_r <= out_tlast ? S_IDLE : S_PREP;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/crr_checker.sv =====
module crr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  // error result is zero and last
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 16'h0)
    else $error("bad error result");
  // no input taken while a result waits
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken with result pending");
endmodule

bind cubic_rational_resampler_top crr_checker u_chk (.*);

// ===== bench/testbench.sv =====
module testbench;
  import crr_pkg::*;

  typedef struct {
    logic [15:0] sample;
    logic        last;
    logic        cfg_err;
  } result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [RegW-1:0]   cfg_data;

  // Samples waiting to be sent, and resampled outputs still to come
  logic [15:0] sample_q[$];
  result_t     resampled_q[$];
  int          fail_count = 0;

  // Shadow of the resampler state
  logic signed [15:0] win[4];
  logic [PhaseW-1:0]  phase;
  logic [1:0]         fill;
  logic [RegW-1:0]    step_reg;
  logic [RegW-1:0]    period_reg;

  cubic_rational_resampler_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Catmull-Rom point at the current phase
  function automatic logic [15:0] interp_point();
    longint t, a, b, c, d, k1, k2, k3, acc;
    t  = (longint'(phase) << 15) / longint'(period_reg);
    a  = win[0];
    b  = win[1];
    c  = win[2];
    d  = win[3];
    k1 = c - a;
    k2 = 2 * a - 5 * b + 4 * c - d;
    k3 = d - a + 3 * (b - c);
    acc = (k3 * t) >>> 15;
    acc = ((k2 + acc) * t) >>> 15;
    acc = ((k1 + acc) * t) >>> 15;
    acc = b + (acc >>> 1);
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  // Advance the shadow state by one accepted sample, queue the outputs
  task automatic resample_sample(input logic [15:0] x);
    result_t r;
    int n;
    n = 0;
    if (step_reg == 0 || period_reg == 0 || step_reg > 192000 || period_reg > 192000 ||
        longint'(period_reg) > 64 * longint'(step_reg)) begin
      r.sample = '0; r.last = 1'b1; r.cfg_err = 1'b1;
      resampled_q.push_back(r);
      return;
    end
    if (fill < 2) begin
      win[fill + 1] = x;
      fill = fill + 1;
      return;
    end
    if (fill == 2) begin
      win[3] = x;
      fill = 3;
    end else begin
      if (phase >= period_reg) phase = phase - period_reg;
      else phase = '0;
      win[0] = win[1];
      win[1] = win[2];
      win[2] = win[3];
      win[3] = x;
    end
    while (phase < period_reg && n < 64) begin
      r.sample = interp_point(); r.last = 1'b0; r.cfg_err = 1'b0;
      resampled_q.push_back(r);
      n++;
      phase = phase + step_reg;
    end
    if (n > 0) resampled_q[$].last = 1'b1;
  endtask

  // Sender: bursts of items with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) resample_sample(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= sample_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between free-running, random and heavy
  int stall_mode, mode_left;
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_mode = 0;
      mode_left  = 50;
    end else begin
      if (out_tvalid && out_tready) begin
        if (resampled_q.size() == 0) begin
          $error("unexpected output item: sample %h", out_tdata);
          fail_count++;
        end else begin
          e = resampled_q.pop_front();
          if (out_tdata !== e.sample) begin
            $error("sample_out: expected %h, got %h", e.sample, out_tdata);
            fail_count++;
          end
          if (out_tlast !== e.last) begin
            $error("last: expected %b, got %b", e.last, out_tlast);
            fail_count++;
          end
          if (out_tuser !== e.cfg_err) begin
            $error("config_error: expected %b, got %b", e.cfg_err, out_tuser);
            fail_count++;
          end
        end
      end
      mode_left--;
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 300);
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[RegW-1:0];
    if (idx == RegStep) step_reg = val[RegW-1:0];
    else period_reg = val[RegW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until the resampler has drained
  task automatic wait_drained();
    while (sample_q.size() > 0 || in_tvalid || resampled_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_rates(input int unsigned st, input int unsigned per);
    write_reg(RegStep, st);
    write_reg(RegPeriod, per);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) sample_q.push_back(16'($urandom));
  endtask

  initial begin
    int unsigned st, per;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    for (int i = 0; i < 4; i++) win[i] = '0;
    phase      = '0;
    fill       = '0;
    step_reg   = 1;
    period_reg = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset rates, field extremes and full-swing steps for saturation
    sample_q.push_back(16'h7fff);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7fff);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'hffff);
    wait_drained();

    // Upsampling by four, overshoot on alternating extremes
    set_rates(1, 4);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7fff);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7fff);
    wait_drained();

    // Longest run per input: period equal to 64 * step
    set_rates(3, 192);
    send_random(2);
    wait_drained();

    // Period just over 64 * step: error items
    set_rates(1, 65);
    send_random(2);
    wait_drained();

    // Zero step, zero period, and rates over the limit
    set_rates(0, 5);
    send_random(1);
    wait_drained();
    set_rates(5, 0);
    send_random(1);
    wait_drained();
    set_rates(262143, 262143);
    send_random(1);
    wait_drained();

    // Both rates at the limit, then a period below the step, then one above it
    set_rates(192000, 192000);
    send_random(2);
    wait_drained();
    set_rates(1000, 1);
    send_random(2);
    wait_drained();
    set_rates(1, 40);
    send_random(2);
    wait_drained();

    // Random rate settings, mostly modest ratios
    for (int ph = 0; ph < 16; ph++) begin
      case ($urandom_range(0, 5))
        0: begin
          st  = $urandom_range(1, 192000);
          per = $urandom_range(1, 192000);
        end
        1: begin
          st  = $urandom_range(1, 3000);
          per = st * 64 + $urandom_range(1, 100);
        end
        default: begin
          st  = $urandom_range(1, 48000);
          per = $urandom_range(1, 4 * st);
          if (per > 192000) per = 192000;
        end
      endcase
      set_rates(st, per);
      send_random(10);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
